// ===== rtl/kc3_pkg.sv =====
`timescale 1ns / 1ps

package kc3_pkg;

  // Field and register widths.
  localparam int PIX_W     = 8;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 13;
  localparam int AREA_W    = WIDTH_W + HEIGHT_W;
  localparam int COEF_W    = 16;
  localparam int KSIZE     = 3;
  localparam int KROW_W    = KSIZE * COEF_W;
  localparam int CONV_W    = 28;
  localparam int PROD_W    = PIX_W + 1 + COEF_W;
  localparam int RSUM_W    = PROD_W + 2;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int RESET_WIDTH   = 1024;
  localparam int RESET_HEIGHT  = 1024;

  // Job queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;

  // Input opcodes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Effective frame geometry after clamping.
  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [AREA_W-1:0]   area;
  } geom_t;

  // Window indexed [row][column], row 0 on top, column 0 on the left.
  typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0] window_t;

  // Kernel indexed by row, row 0 weights the row above the center.
  typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;

  typedef struct packed {
    window_t pix;
    logic    top_off;
    logic    bot_off;
    logic    left_off;
    logic    right_off;
    logic    last;
  } job_t;

endpackage

// ===== rtl/kc3_pix_if.sv =====
`timescale 1ns / 1ps

interface kc3_pix_if;
  import kc3_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output opcode, output pixel, input ready);
  modport sink (input valid, input opcode, input pixel, output ready);
endinterface

// ===== rtl/kc3_res_if.sv =====
`timescale 1ns / 1ps

interface kc3_res_if;
  import kc3_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CONV_W-1:0] conv_value;
  logic                     frame_last;

  modport source (output valid, output conv_value, output frame_last, input ready);
  modport sink (input valid, input conv_value, input frame_last, output ready);
endinterface

// ===== rtl/kernel_convolution_3x3_unit.sv =====
`timescale 1ns / 1ps
// The item that completes a neighborhood (one row and one column after its own pixel)
// passes the read stage, job queue, product and row sum registers and output register.
// One item per cycle unless the queue fills; the line store has one read and write port.
// Reset is synchronous and active high; it clears the position counters, the window,
// the job queue and the pipeline, and loads the register defaults. The line store is
// not cleared and needs no clearing pass.
module kernel_convolution_3x3_unit #(
  parameter int MAX_WIDTH = kc3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  kc3_pix_if.sink                       pixels,
  kc3_res_if.source                     results,
  input  logic                          cfg_we,
  input  logic [kc3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kc3_pkg::KROW_W-1:0]    cfg_data
);
  import kc3_pkg::*;

  // Configuration registers as written.
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  kernel_t             kernel;

  geom_t               geom;

  // Front to back job queue.
  logic                q_push;
  job_t                q_push_job;
  logic                q_pop;
  logic                q_head_valid;
  job_t                q_head_job;
  logic [QCNT_W-1:0]   q_count;

  // Register writes. Index values with no register behind them are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_W'(RESET_WIDTH);
      height_reg <= HEIGHT_W'(RESET_HEIGHT);
      kernel     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   width_reg <= cfg_data[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:  height_reg <= cfg_data[HEIGHT_W-1:0];
        REG_KERNEL_TOP:    kernel[0] <= cfg_data;
        REG_KERNEL_MIDDLE: kernel[1] <= cfg_data;
        REG_KERNEL_BOTTOM: kernel[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The frame size is clamped to a valid range so that a zero or oversized
  // setting still produces a well-formed frame. The pixel count of the frame
  // decides which output carries the end-of-frame mark.
  always_comb begin
    if (width_reg == '0) begin
      geom.width = WIDTH_W'(1);
    end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      geom.width = WIDTH_W'(MAX_WIDTH);
    end else begin
      geom.width = width_reg;
    end

    if (height_reg == '0) begin
      geom.height = HEIGHT_W'(1);
    end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
      geom.height = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      geom.height = height_reg;
    end

    geom.area = AREA_W'(geom.width) * AREA_W'(geom.height);
  end

  // The front takes one item per transfer, tracks the raster position, keeps
  // the line store and the 3x3 window up to date and decides whether the item
  // closes a neighborhood. Only items that do are queued as jobs.
  kc3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels),
    .geom    (geom),
    .q_count (q_count),
    .push    (q_push),
    .job     (q_push_job)
  );

  // The queue lets the front keep taking pixels while the output side stalls.
  kc3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .count      (q_count)
  );

  // The back multiplies the window by the kernel, adds up the products in two
  // registered steps and holds the result in the output register.
  kc3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_head_valid),
    .job       (q_head_job),
    .pop       (q_pop),
    .kernel    (kernel),
    .results   (results)
  );

endmodule

// ===== rtl/kc3_ram.sv =====
`timescale 1ns / 1ps

module kc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/kc3_front.sv =====
`timescale 1ns / 1ps

module kc3_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  kc3_pix_if.sink                      pixels,
  input  kc3_pkg::geom_t               geom,
  input  logic [kc3_pkg::QCNT_W-1:0]   q_count,
  output logic                         push,
  output kc3_pkg::job_t                job
);
  import kc3_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int CMP_W  = ((ADDR_W > WIDTH_W) ? ADDR_W : WIDTH_W) + 1;
  localparam int ROWX_W = HEIGHT_W + 1;
  localparam int AX_W   = AREA_W + 1;
  localparam int WORD_W = 2 * PIX_W;

  // Position counters.
  logic [ADDR_W-1:0]   col, col_next;
  logic [HEIGHT_W-1:0] row, row_next;
  logic [AREA_W-1:0]   done, done_next;

  logic                fire;
  logic [CMP_W-1:0]    col_x, col_inc, w_x;
  logic [ROWX_W-1:0]   row_x, h_x;
  logic                have1, have2, have;
  logic                top_off, bot_off, left_off, right_off, last;

  // Stage holding the item while the line store read completes.
  logic                sa_valid;
  logic [PIX_W-1:0]    sa_pix;
  logic [ADDR_W-1:0]   sa_col;
  logic                sa_fwd;
  logic [WORD_W-1:0]   sa_fwd_word;
  logic                sa_have;
  logic                sa_top_off, sa_bot_off, sa_left_off, sa_right_off, sa_last;

  logic [WORD_W-1:0]   rdata, word, wdata;
  window_t             window, window_next;

  // Each word holds {pixel two rows back, pixel one row back} for a column.
  kc3_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (sa_valid),
    .waddr (sa_col),
    .wdata (wdata),
    .raddr (col),
    .rdata (rdata)
  );

  assign fire = pixels.valid && pixels.ready;

  // Room is reserved for the item still in the read stage.
  assign pixels.ready = !((q_count == QCNT_W'(QDEPTH)) ||
                          ((q_count == QCNT_W'(QDEPTH - 1)) && sa_valid));

  always_comb begin
    col_x   = CMP_W'(col);
    w_x     = CMP_W'(geom.width);
    col_inc = col_x + CMP_W'(1);
    row_x   = ROWX_W'(row);
    h_x     = ROWX_W'(geom.height);

    // A center inside the row just finished, or the last column two rows back.
    have1 = (col != '0) && (row != '0);
    have2 = (col == '0) && (row_x >= ROWX_W'(2));
    have  = have1 || have2;

    top_off   = have1 ? (row == HEIGHT_W'(1)) : (row == HEIGHT_W'(2));
    bot_off   = have1 ? (row_x >= h_x) : (row_x >= h_x + ROWX_W'(1));
    left_off  = have1 ? (col == ADDR_W'(1)) : (geom.width == WIDTH_W'(1));
    right_off = have1 ? (col_x >= w_x) : 1'b1;
    last      = have && ((AX_W'(done) + AX_W'(1)) >= AX_W'(geom.area));

    col_next  = col;
    row_next  = row;
    done_next = done;
    if (col_inc >= w_x) begin
      col_next = '0;
      row_next = row + HEIGHT_W'(1);
    end else begin
      col_next = ADDR_W'(col_inc);
    end
    if (have) begin
      if (last) begin
        col_next  = '0;
        row_next  = '0;
        done_next = '0;
      end else begin
        done_next = done + AREA_W'(1);
      end
    end
  end

  always_comb begin
    // A write still in flight to the same column is taken from the bypass.
    word  = sa_fwd ? sa_fwd_word : rdata;
    wdata = {word[PIX_W-1:0], sa_pix};

    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE - 1; c++) begin
        window_next[r][c] = window[r][c+1];
      end
    end
    window_next[0][KSIZE-1] = word[WORD_W-1:PIX_W];
    window_next[1][KSIZE-1] = word[PIX_W-1:0];
    window_next[2][KSIZE-1] = sa_pix;

    push          = sa_valid && sa_have;
    job.pix       = window_next;
    job.top_off   = sa_top_off;
    job.bot_off   = sa_bot_off;
    job.left_off  = sa_left_off;
    job.right_off = sa_right_off;
    job.last      = sa_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      done     <= '0;
      sa_valid <= 1'b0;
      window   <= '0;
    end else begin
      if (fire) begin
        col  <= col_next;
        row  <= row_next;
        done <= done_next;
      end
      sa_valid <= fire;
      if (sa_valid) begin
        window <= window_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sa_pix       <= (pixels.opcode == OP_FLUSH) ? '0 : pixels.pixel;
      sa_col       <= col;
      sa_fwd       <= sa_valid && (sa_col == col);
      sa_fwd_word  <= wdata;
      sa_have      <= have;
      sa_top_off   <= top_off;
      sa_bot_off   <= bot_off;
      sa_left_off  <= left_off;
      sa_right_off <= right_off;
      sa_last      <= last;
    end
  end

endmodule

// ===== rtl/kc3_queue.sv =====
`timescale 1ns / 1ps

module kc3_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  kc3_pkg::job_t              push_job,
  input  logic                       pop,
  output logic                       head_valid,
  output kc3_pkg::job_t              head_job,
  output logic [kc3_pkg::QCNT_W-1:0] count
);
  import kc3_pkg::*;

  job_t              entries [QDEPTH];
  logic [QIDX_W-1:0] wr_ptr, rd_ptr;

  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QIDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QIDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/kc3_back.sv =====
`timescale 1ns / 1ps

module kc3_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  kc3_pkg::job_t    job,
  output logic             pop,
  input  kc3_pkg::kernel_t kernel,
  kc3_res_if.source        results
);
  import kc3_pkg::*;

  logic                     adv;
  logic                     v1, v2, v3;
  logic                     last1, last2, last3;
  logic signed [PROD_W-1:0] prod [KSIZE][KSIZE];
  logic signed [PROD_W-1:0] prod_next [KSIZE][KSIZE];
  logic signed [RSUM_W-1:0] rsum [KSIZE];
  logic signed [RSUM_W-1:0] rsum_next [KSIZE];
  logic signed [CONV_W-1:0] total, conv;

  assign adv = !v3 || results.ready;
  assign pop = adv && job_valid;

  // One multiplier per window tap; taps outside the image count as zero.
  always_comb begin
    logic signed [PROD_W-1:0] pe;
    logic signed [PROD_W-1:0] ce;
    logic                     off;
    for (int r = 0; r < KSIZE; r++) begin
      for (int c = 0; c < KSIZE; c++) begin
        off = ((r == 0) && job.top_off) || ((r == KSIZE - 1) && job.bot_off) ||
              ((c == 0) && job.left_off) || ((c == KSIZE - 1) && job.right_off);
        pe  = off ? '0 : PROD_W'(signed'({1'b0, job.pix[r][c]}));
        ce  = PROD_W'(signed'(kernel[r][COEF_W*c +: COEF_W]));
        prod_next[r][c] = pe * ce;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < KSIZE; r++) begin
      rsum_next[r] = RSUM_W'(prod[r][0]) + RSUM_W'(prod[r][1]) + RSUM_W'(prod[r][2]);
    end
    total = CONV_W'(rsum[0]) + CONV_W'(rsum[1]) + CONV_W'(rsum[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= job_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod  <= prod_next;
      last1 <= job.last;
      rsum  <= rsum_next;
      last2 <= last1;
      conv  <= total;
      last3 <= last2;
    end
  end

  assign results.valid      = v3;
  assign results.conv_value = conv;
  assign results.frame_last = last3;

endmodule
